// File: sv/fls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade light sequencer package
// Shared types, codes and widths for the sequencer controller and datapath.
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned LevelW  = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned DivCntW = $clog2(TimeW);

    // PWM full-scale count; the reset maximum level clamps it to 8 bits
    localparam int unsigned PwmRange = 255;
    localparam logic [LevelW-1:0] MaxLevelReset =
        (PwmRange > 255) ? LevelW'(255) : LevelW'(PwmRange);

    localparam logic [TimeW-1:0] BrightenReset = TimeW'(1000);
    localparam logic [TimeW-1:0] FadeReset     = TimeW'(1000);
    localparam logic [TimeW-1:0] HoldReset     = TimeW'(60000);

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_BRIGHTEN = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FADE     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd2;

    // Item kinds carried on tuser
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_MAX  = 2'd2;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_BRIGHTEN = 2'd1,
        MODE_ON       = 2'd2,
        MODE_FADE     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_fls_state;

    typedef struct packed {
        logic capture;    // latch the input word, advance the ms counter on a tick
        logic div_start;  // launch the step-delay division
        logic apply;      // commit the state update and load the result
    } t_fls_cmd;

    typedef struct packed {
        logic need_div;   // this item takes a ramp step
        logic div_done;   // last division iteration in this cycle
        logic out_free;   // result register can take a new word
    } t_fls_sts;

endpackage

// File: sv/fls_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step delay divider
// Restoring divider, one quotient bit per cycle: 32-bit time by 8-bit level.
// ----------------------------------------------------------------------------
module fls_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fls_pkg::TimeW-1:0]     i_dividend,
    input  logic [fls_pkg::LevelW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [fls_pkg::TimeW-1:0]     o_quotient
);
    import fls_pkg::*;

    logic                r_busy, n_busy;
    logic [DivCntW-1:0]  r_cnt, n_cnt;
    logic [TimeW-1:0]    r_quo, n_quo;
    logic [LevelW-1:0]   r_rem, n_rem;
    logic [LevelW-1:0]   r_dsr, n_dsr;
    logic [LevelW:0]     w_shifted;
    logic                w_ge;

    assign w_shifted = {r_rem, r_quo[TimeW-1]};
    assign w_ge      = (w_shifted >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem = w_ge ? LevelW'(w_shifted - {1'b0, r_dsr}) : w_shifted[LevelW-1:0];
            n_quo = {r_quo[TimeW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DivCntW'(TimeW - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_busy && (r_cnt == DivCntW'(TimeW - 1));
    assign o_quotient = r_quo;

endmodule

// File: sv/fls_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade light sequencer datapath
// Time, level and mode registers, next-state logic and the result register.
// ----------------------------------------------------------------------------
module fls_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fls_pkg::t_fls_cmd             i_cmd,
    output fls_pkg::t_fls_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [fls_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [fls_pkg::TimeW-1:0]     i_cfg_wdata,
    input  logic [1:0]                    i_action,
    input  logic [fls_pkg::LevelW-1:0]    i_new_max,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fls_pkg::LevelW-1:0]    o_brightness,
    output logic [1:0]                    o_light_mode,
    output logic                          o_pwm_update,
    output logic                          o_mode_changed
);
    import fls_pkg::*;

    logic [TimeW-1:0]  r_bright_t, r_fade_t, r_hold_t;
    logic [TimeW-1:0]  r_now, r_due, n_due;
    logic [LevelW-1:0] r_level, n_level, r_written, r_max, n_max;
    t_mode             r_mode, n_mode;
    logic [1:0]        r_action;
    logic [LevelW-1:0] r_new_max;

    logic              r_out_valid;
    logic [LevelW-1:0] r_out_level;
    t_mode             r_out_mode;
    logic              r_out_pwm, r_out_chg;

    logic              w_step, w_turn_on, w_need_div, w_chg, w_pwm;
    logic              w_use_hold;
    logic [TimeW-1:0]  w_quo, w_dividend;
    logic              w_div_done;

    assign w_dividend = (r_mode == MODE_BRIGHTEN) ? r_bright_t : r_fade_t;

    fls_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_max),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_turn_on = (r_action == ACT_ON);
    assign w_step    = w_turn_on ||
                       ((r_action == ACT_TICK) && (r_mode != MODE_OFF) && (r_now > r_due));

    always_comb begin
        n_level    = r_level;
        n_mode     = r_mode;
        n_max      = r_max;
        w_chg      = 1'b0;
        w_need_div = 1'b0;
        w_use_hold = 1'b0;
        if (w_step) begin
            case (r_mode)
                MODE_OFF: begin
                    if (w_turn_on) begin
                        n_mode = MODE_BRIGHTEN;
                        w_chg  = 1'b1;
                    end
                end
                MODE_BRIGHTEN: begin
                    if (r_level >= r_max) begin
                        w_use_hold = 1'b1;
                        n_mode     = MODE_ON;
                        w_chg      = 1'b1;
                    end else begin
                        w_need_div = 1'b1;
                        n_level    = r_level + 1'b1;
                    end
                end
                MODE_ON: begin
                    if (w_turn_on) begin
                        w_use_hold = 1'b1;
                    end else begin
                        n_mode = MODE_FADE;
                        w_chg  = 1'b1;
                    end
                end
                default: begin
                    if (w_turn_on) begin
                        n_mode = MODE_BRIGHTEN;
                        w_chg  = 1'b1;
                    end else if (r_level == '0) begin
                        n_mode = MODE_OFF;
                        w_chg  = 1'b1;
                    end else begin
                        w_need_div = 1'b1;
                        n_level    = r_level - 1'b1;
                    end
                end
            endcase
        end
        // new maximum; zero or unchanged is dropped
        if ((r_action == ACT_MAX) && (r_new_max != '0) && (r_new_max != r_max)) begin
            n_max = r_new_max;
            if (r_mode == MODE_ON) begin
                n_level = r_new_max;
            end
        end
    end

    always_comb begin
        n_due = r_due;
        if (w_use_hold) begin
            n_due = r_now + r_hold_t;
        end else if (w_need_div) begin
            n_due = r_now + w_quo;
        end
    end

    assign w_pwm = (r_action == ACT_TICK) && (r_mode != MODE_OFF) && (n_level != r_written);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_t  <= BrightenReset;
            r_fade_t    <= FadeReset;
            r_hold_t    <= HoldReset;
            r_now       <= '0;
            r_due       <= '0;
            r_level     <= '0;
            r_written   <= '0;
            r_max       <= MaxLevelReset;
            r_mode      <= MODE_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BRIGHTEN: r_bright_t <= i_cfg_wdata;
                    CFG_FADE:     r_fade_t   <= i_cfg_wdata;
                    CFG_HOLD:     r_hold_t   <= i_cfg_wdata;
                    default:      ;
                endcase
            end
            if (i_cmd.capture && (i_action == ACT_TICK)) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.apply) begin
                r_due   <= n_due;
                r_level <= n_level;
                r_max   <= n_max;
                r_mode  <= n_mode;
                if (w_pwm) begin
                    r_written <= n_level;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_action  <= i_action;
            r_new_max <= i_new_max;
        end
        if (i_cmd.apply) begin
            r_out_level <= n_level;
            r_out_mode  <= n_mode;
            r_out_pwm   <= w_pwm;
            r_out_chg   <= w_chg;
        end
    end

    assign o_sts.need_div = w_need_div;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_brightness   = r_out_level;
    assign o_light_mode   = r_out_mode;
    assign o_pwm_update   = r_out_pwm;
    assign o_mode_changed = r_out_chg;

endmodule

// File: sv/fls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade light sequencer controller
// Sequences capture, optional division and commit for one word at a time.
// ----------------------------------------------------------------------------
module fls_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fls_pkg::t_fls_sts    i_sts,
    output fls_pkg::t_fls_cmd    o_cmd
);
    import fls_pkg::*;

    t_fls_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_sts.need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EVAL: begin
                o_cmd.div_start = i_sts.need_div;
            end
            ST_DONE: begin
                o_cmd.apply = i_sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/fade_light_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade light sequencer
// LED level sequencer with off, brighten, on and fade modes.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. A word that takes no
// ramp step passes through capture, evaluation and commit; a ramp step also
// waits in the serial divider that computes the step delay (ramp time divided
// by the maximum level). The input is ready again the cycle after the result
// is loaded into the output register, which holds it until the sink takes it.
// Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module fade_light_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fls_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [fls_pkg::TimeW-1:0]     i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] new_max
    input  logic [1:0]                    i_s_axis_tuser,  // [1:0] action
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] brightness, [9:8] light_mode, [10] pwm_update, [11] mode_changed
    output logic [15:0]                   o_m_axis_tdata
);
    import fls_pkg::*;

    t_fls_cmd          w_cmd;
    t_fls_sts          w_sts;
    logic [LevelW-1:0] w_brightness;
    logic [1:0]        w_light_mode;
    logic              w_pwm_update, w_mode_changed;

    fls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fls_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_s_axis_tuser),
        .i_new_max      (i_s_axis_tdata),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_brightness   (w_brightness),
        .o_light_mode   (w_light_mode),
        .o_pwm_update   (w_pwm_update),
        .o_mode_changed (w_mode_changed)
    );

    assign o_m_axis_tdata = {4'b0000, w_mode_changed, w_pwm_update, w_light_mode, w_brightness};

endmodule

// File: sv/fls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade light sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fls_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [15:0]                   o_m_axis_tdata
);
    import fls_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // off mode always shows a dark level
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[9:8] == MODE_OFF) |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("off mode with nonzero brightness");

    // one word in flight: input closes right after acceptance
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("input ready while a word is in work");

    // a result does not rise right after acceptance
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind fade_light_sequencer fls_checker u_fls_checker (.*);
